// ===== hdl/sorted_priority_queue_macros.svh =====
// Assertion wrappers for the sorted priority queue.
// Both forms sample on clk and stand down while rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue check failed");
// Next-cycle implication.
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue check failed");
`else
`define SPQ_ASSERT_NOW(lbl, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/spq_pkg.sv =====
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int MODE_W    = 2;
    localparam int KEY_W     = 12;
    localparam int CRED_W    = 9;
    localparam int IDENT_W   = 20;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_EXTRACT = 2'd1,
        MODE_CLEAR   = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [CRED_W-1:0]  credits;
        logic [IDENT_W-1:0] ident;
    } rec_t;

endpackage

// ===== hdl/sorted_priority_queue.sv =====
// Sorted priority queue: holds up to DEPTH records (key, credits, ident) and
// hands back the one with the highest key; equal keys leave in arrival order.
// Command channel: an operation (mode plus the record fields) is taken at a
// rising edge where start is high and busy is low. Result channel: done
// pulses for one cycle with status, got_record, out_key, out_credits,
// out_ident and count; the receiver cannot hold it off, and busy is already
// low in that cycle so the next command may follow at once.
// Sequence from acceptance to the done cycle:
//   clear, unused mode, insert when full, extract when empty: the result is
//     registered straight from the idle state, and busy never rises.
//   extract: one registered read of the top entry, then the result.
//   insert: each held record whose key is not below the new key moves
//     up one slot per cycle through the single memory port pair and the
//     one key comparator; then the new record is written into the hole.
// One command is in flight at a time; a new one is taken only once busy is low.
// Records sit in the memory in ascending key order, so the highest key is
// always at slot count-1 and extract moves nothing.
// Reset clears the count and the sequencer; memory contents are not
// cleared and are only read below the count.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [spq_pkg::MODE_W-1:0]    mode,
    input  logic [spq_pkg::KEY_W-1:0]     key,
    input  logic [spq_pkg::CRED_W-1:0]    credits,
    input  logic [spq_pkg::IDENT_W-1:0]   ident,
    output logic                          busy,
    output logic                          done,
    output logic [spq_pkg::STATUS_W-1:0]  status,
    output logic                          got_record,
    output logic [spq_pkg::KEY_W-1:0]     out_key,
    output logic [spq_pkg::CRED_W-1:0]    out_credits,
    output logic [spq_pkg::IDENT_W-1:0]   out_ident,
    output logic [spq_pkg::COUNT_W-1:0]   count
);

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int COUNT_W = spq_pkg::COUNT_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_EXT_OUT
    } state_t;

    // Sequencer and registered result.
    state_t                         state_reg, state_next;
    logic [CW-1:0]                  occ_reg, occ_next;
    logic [CW-1:0]                  idx_reg, idx_next;
    spq_pkg::rec_t                  new_rec_reg, new_rec_next;
    logic                           done_reg, done_next;
    logic [spq_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                           got_reg, got_next;
    spq_pkg::rec_t                  out_rec_reg, out_rec_next;
    logic [COUNT_W-1:0]             count_reg, count_next;

    // Record store, one write and one registered read per cycle.
    spq_pkg::rec_t                  mem [DEPTH];
    spq_pkg::rec_t                  rd_data_reg;
    logic [AW-1:0]                  rd_addr;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    spq_pkg::rec_t                  wr_data;

    // Result staging inside the sequencer.
    logic                           res_fire;
    logic [spq_pkg::STATUS_W-1:0]   res_status;
    logic                           res_got;
    spq_pkg::rec_t                  res_rec;
    logic [CW-1:0]                  res_cnt;

    logic [CW-1:0]                  occ_m1;
    logic [CW-1:0]                  occ_p1;
    logic [CW-1:0]                  idx_m1;
    logic [CW-1:0]                  idx_m2;
    logic                           shift_up;

    assign occ_m1   = occ_reg - CW'(1);
    assign occ_p1   = occ_reg + CW'(1);
    assign idx_m1   = idx_reg - CW'(1);
    assign idx_m2   = idx_reg - CW'(2);
    // The shared comparator: move the entry below the hole up while its key
    // is not below the new key, so older equal keys stay nearer the top.
    assign shift_up = (rd_data_reg.key >= new_rec_reg.key);

    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        idx_next     = idx_reg;
        new_rec_next = new_rec_reg;
        rd_addr      = '0;
        wr_en        = 1'b0;
        wr_addr      = idx_reg[AW-1:0];
        wr_data      = rd_data_reg;
        res_fire     = 1'b0;
        res_status   = spq_pkg::STAT_OK;
        res_got      = 1'b0;
        res_rec      = '0;
        res_cnt      = occ_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    new_rec_next = '{key: key, credits: credits, ident: ident};
                    unique case (mode)
                        spq_pkg::MODE_INSERT:
                        begin
                            if (occ_reg == FULL_COUNT)
                            begin
                                res_fire   = 1'b1;
                                res_status = spq_pkg::STAT_FULL;
                            end
                            else if (occ_reg == '0)
                            begin
                                idx_next   = '0;
                                state_next = ST_INS_PUT;
                            end
                            else
                            begin
                                idx_next   = occ_reg;
                                rd_addr    = occ_m1[AW-1:0];
                                state_next = ST_INS_CMP;
                            end
                        end
                        spq_pkg::MODE_EXTRACT:
                        begin
                            if (occ_reg == '0)
                            begin
                                res_fire   = 1'b1;
                                res_status = spq_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = occ_m1[AW-1:0];
                                state_next = ST_EXT_OUT;
                            end
                        end
                        spq_pkg::MODE_CLEAR:
                        begin
                            occ_next = '0;
                            res_fire = 1'b1;
                            res_cnt  = '0;
                        end
                        default:
                        begin
                            res_fire = 1'b1;
                        end
                    endcase
                end
            end
            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (shift_up)
                begin
                    // Move the entry up and open the hole one slot lower.
                    wr_data  = rd_data_reg;
                    idx_next = idx_m1;
                    if (idx_m1 == '0)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        rd_addr = idx_m2[AW-1:0];
                    end
                end
                else
                begin
                    wr_data    = new_rec_reg;
                    occ_next   = occ_p1;
                    res_fire   = 1'b1;
                    res_cnt    = occ_p1;
                    state_next = ST_IDLE;
                end
            end
            ST_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_data    = new_rec_reg;
                occ_next   = occ_p1;
                res_fire   = 1'b1;
                res_cnt    = occ_p1;
                state_next = ST_IDLE;
            end
            ST_EXT_OUT:
            begin
                occ_next   = occ_m1;
                res_fire   = 1'b1;
                res_got    = 1'b1;
                res_rec    = rd_data_reg;
                res_cnt    = occ_m1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        done_next    = res_fire;
        status_next  = status_reg;
        got_next     = got_reg;
        out_rec_next = out_rec_reg;
        count_next   = count_reg;
        if (res_fire)
        begin
            status_next  = res_status;
            got_next     = res_got;
            out_rec_next = res_rec;
            count_next   = COUNT_W'(res_cnt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            idx_reg     <= '0;
            new_rec_reg <= '0;
            done_reg    <= 1'b0;
            status_reg  <= spq_pkg::STAT_OK;
            got_reg     <= 1'b0;
            out_rec_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            idx_reg     <= idx_next;
            new_rec_reg <= new_rec_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            got_reg     <= got_next;
            out_rec_reg <= out_rec_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign got_record  = got_reg;
    assign out_key     = out_rec_reg.key;
    assign out_credits = out_rec_reg.credits;
    assign out_ident   = out_rec_reg.ident;
    assign count       = count_reg;

    `SPQ_ASSERT_NOW(a_occ_bounded, 1'b1, occ_reg <= FULL_COUNT)
    `SPQ_ASSERT_NOW(a_walk_above_bottom, state_reg == ST_INS_CMP, idx_reg != '0)
    `SPQ_ASSERT_NOW(a_extract_nonempty, state_reg == ST_EXT_OUT, occ_reg != '0)
    `SPQ_ASSERT_NEXT(a_full_rejects, start && !busy && mode == spq_pkg::MODE_INSERT && occ_reg == FULL_COUNT, done && status == spq_pkg::STAT_FULL && occ_reg == FULL_COUNT)
    `SPQ_ASSERT_NOW(a_record_ok, done && got_record, status == spq_pkg::STAT_OK && !busy)

endmodule
